### rtl/ami_pkg.sv
package ami_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int THR_BITS      = 16;
  localparam int ROW_BITS      = 2;
  localparam int IO_BITS       = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COF,
    ST_DET,
    ST_CHECK,
    ST_DIV,
    ST_DIV_WAIT,
    ST_TR,
    ST_EMIT
  } ami_state_t;

endpackage

### rtl/ami_divider.sv
// Restoring signed divider, one quotient bit per cycle.
module ami_divider #(
  parameter int NB = 128,
  parameter int DB = 100
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic signed [NB-1:0] num,
  input  logic signed [DB-1:0] den,
  output logic                 done,
  output logic signed [NB-1:0] quo
);
  import ami_pkg::*;

  localparam int CB = $clog2(NB + 1);

  logic [NB-1:0] n_mag, q;
  logic [DB-1:0] d_mag;
  logic [DB:0]   r;
  logic [DB:0]   r_sh;
  logic [DB+1:0] diff;
  logic [CB-1:0] cnt;
  logic          neg_q, run;

  // shift in next numerator bit and trial subtract
  always_comb begin
    r_sh = {r[DB-1:0], n_mag[NB-1]};
    diff = {1'b0, r_sh} - {2'b00, d_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        cnt   <= CB'(NB);
        n_mag <= num[NB-1] ? NB'(-num) : num;
        d_mag <= den[DB-1] ? DB'(-den) : den;
        neg_q <= num[NB-1] ^ den[DB-1];
        r     <= '0;
        q     <= '0;
      end else if (run) begin
        n_mag <= {n_mag[NB-2:0], 1'b0};
        if (!diff[DB+1]) begin
          r <= diff[DB:0];
          q <= {q[NB-2:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[NB-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg_q ? NB'(-q) : q;

endmodule

### rtl/affine_matrix_inverse_top.sv
// Affine 3x4 matrix inverse, signed fixed point, one shared multiplier and divider.
// A non-final row item is stored while idle. A final row item keeps busy high through
// cofactors, determinant, singular check, nine bit-serial divisions and translation;
// when singular the divisions and translation are skipped. Three result rows follow
// on consecutive cycles, the last one in the first cycle after busy falls.
// Reset: synchronous, active high; clears control and sets threshold to 1.
module affine_matrix_inverse_top #(
  parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = ami_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we,
  input  logic [ami_pkg::THR_BITS-1:0]        cfg_data,
  input  logic [ami_pkg::ROW_BITS-1:0]        row_index,
  input  logic signed [ami_pkg::IO_BITS-1:0]  elem_first,
  input  logic signed [ami_pkg::IO_BITS-1:0]  elem_second,
  input  logic signed [ami_pkg::IO_BITS-1:0]  elem_third,
  input  logic signed [ami_pkg::IO_BITS-1:0]  elem_offset,
  input  logic                                final_row,
  output logic                                res_valid,
  output logic [ami_pkg::ROW_BITS-1:0]        out_row,
  output logic signed [ami_pkg::IO_BITS-1:0]  res_first,
  output logic signed [ami_pkg::IO_BITS-1:0]  res_second,
  output logic signed [ami_pkg::IO_BITS-1:0]  res_third,
  output logic signed [ami_pkg::IO_BITS-1:0]  res_offset,
  output logic                                singular,
  output logic                                last_out
);
  import ami_pkg::*;

  localparam int S   = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int PB  = 2 * S + 2;      // product width
  localparam int CFB = 2 * S + 1;      // cofactor width
  localparam int DTB = 3 * S + 3;      // determinant width
  localparam int NB  = CFB + 2 * FRAC_BITS;
  localparam int AB  = 2 * S + 3;      // translation accumulator width
  localparam int THB = THR_BITS + 1 + 2 * FRAC_BITS;
  localparam int CMPB = (DTB > THB) ? DTB : THB;  // singular compare width

  // stored matrix: row-major 3x4
  logic signed [S-1:0] m [12];
  logic [THR_BITS-1:0] thr;

  ami_state_t state, state_next;
  logic [3:0] idx;
  logic [1:0] ph;
  logic [1:0] dj;
  logic signed [CFB-1:0] adj [9];
  logic signed [DTB-1:0] det;
  logic signed [S-1:0]   inv [9];
  logic signed [S-1:0]   tr [3];
  logic signed [AB-1:0]  acc;
  logic signed [AB-1:0]  tr_sum;
  logic signed [PB-1:0]  prod;
  logic signed [S:0]     ma, mb;
  logic signed [CFB-1:0] prod_keep;
  logic                  sing;
  logic [1:0]            emit_row;
  logic                  div_go, div_done;
  logic signed [NB-1:0]  div_q;

  assign busy = (state != ST_IDLE);

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) thr <= THR_BITS'(1);
    else if (cfg_we) thr <= cfg_data;
  end

  // row and column of a 3x3 entry index
  function automatic logic [1:0] k_row(input logic [3:0] k);
    return (k >= 4'd6) ? 2'd2 : ((k >= 4'd3) ? 2'd1 : 2'd0);
  endfunction

  function automatic logic [1:0] k_col(input logic [3:0] k);
    logic [3:0] c;
    c = k - 4'(k_row(k)) * 4'd3;
    return c[1:0];
  endfunction

  // cofactor index helpers: adj[i][j] = m[j1][i1]*m[j2][i2] - m[j1][i2]*m[j2][i1]
  function automatic logic [3:0] cof_a(input logic [3:0] k, input logic sec);
    logic [1:0] i, j, i1, i2, j1;
    i  = k_row(k);
    j  = k_col(k);
    i1 = (i == 2'd2) ? 2'd0 : i + 2'd1;
    i2 = (i == 2'd0) ? 2'd2 : i - 2'd1;
    j1 = (j == 2'd2) ? 2'd0 : j + 2'd1;
    return sec ? 4'(j1 * 4 + i2) : 4'(j1 * 4 + i1);
  endfunction

  function automatic logic [3:0] cof_b(input logic [3:0] k, input logic sec);
    logic [1:0] i, j, i1, i2, j2;
    i  = k_row(k);
    j  = k_col(k);
    i1 = (i == 2'd2) ? 2'd0 : i + 2'd1;
    i2 = (i == 2'd0) ? 2'd2 : i - 2'd1;
    j2 = (j == 2'd0) ? 2'd2 : j - 2'd1;
    return sec ? 4'(j2 * 4 + i1) : 4'(j2 * 4 + i2);
  endfunction

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_COF: begin
        ma = (S+1)'(m[cof_a(idx, ph[0])]);
        mb = (S+1)'(m[cof_b(idx, ph[0])]);
      end
      ST_DET: begin
        // m[0][j] * adj[j][0], low half unsigned then high half signed
        ma = (S+1)'(m[4'(dj)]);
        if (ph[0]) mb = $signed(adj[4'(dj * 3)][CFB-1:S]);
        else mb = $signed({1'b0, adj[4'(dj * 3)][S-1:0]});
      end
      ST_TR: begin
        if (idx != 4'd9) begin
          ma = (S+1)'(inv[idx]);
          mb = (S+1)'(m[{k_col(idx), 2'd3}]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod <= ma * mb;

  ami_divider #(.NB(NB), .DB(DTB)) u_div (
    .clk (clk),
    .rst (rst),
    .go  (div_go),
    .num (NB'(adj[idx]) <<< (2 * FRAC_BITS)),
    .den (det),
    .done(div_done),
    .quo (div_q)
  );

  function automatic logic signed [S-1:0] sat_n(input logic signed [NB-1:0] v);
    logic signed [NB-1:0] hi, lo;
    hi = NB'({1'b0, {(S-1){1'b1}}});
    lo = -hi - NB'(1);
    if (v > hi) return {1'b0, {(S-1){1'b1}}};
    if (v < lo) return {1'b1, {(S-1){1'b0}}};
    return v[S-1:0];
  endfunction

  function automatic logic signed [S-1:0] sat_a(input logic signed [AB-1:0] v);
    logic signed [AB-1:0] hi, lo;
    hi = AB'({1'b0, {(S-1){1'b1}}});
    lo = -hi - AB'(1);
    if (v > hi) return {1'b0, {(S-1){1'b1}}};
    if (v < lo) return {1'b1, {(S-1){1'b0}}};
    return v[S-1:0];
  endfunction

  logic signed [CMPB-1:0] det_mag;
  logic signed [CMPB-1:0] thr_sh;
  assign det_mag = CMPB'(det[DTB-1] ? -det : det);
  assign thr_sh  = CMPB'({1'b0, thr}) <<< (2 * FRAC_BITS);
  assign prod_keep = CFB'(prod);
  assign tr_sum = acc + AB'(prod);

  // next state
  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    unique case (state)
      ST_IDLE:     if (start && final_row) state_next = ST_COF;
      ST_COF:      if (idx == 4'd8 && ph == 2'd2) state_next = ST_DET;
      ST_DET:      if (dj == 2'd2 && ph == 2'd2) state_next = ST_CHECK;
      ST_CHECK:    state_next = (det == '0 || det_mag < thr_sh) ? ST_EMIT : ST_DIV;
      ST_DIV: begin
        div_go     = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (div_done) state_next = (idx == 4'd8) ? ST_TR : ST_DIV;
      ST_TR:       if (idx == 4'd9) state_next = ST_EMIT;
      ST_EMIT:     if (emit_row == 2'd2) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      ph       <= '0;
      dj       <= '0;
      emit_row <= '0;
      sing     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start && row_index != 2'd3) begin
            m[{row_index, 2'd0}] <= elem_first[S-1:0];
            m[{row_index, 2'd1}] <= elem_second[S-1:0];
            m[{row_index, 2'd2}] <= elem_third[S-1:0];
            m[{row_index, 2'd3}] <= elem_offset[S-1:0];
          end
          idx <= '0; ph <= '0; dj <= '0; emit_row <= '0; det <= '0;
        end
        ST_COF: begin
          // ph0 issue a, ph1 issue b (capture a), ph2 capture b
          if (ph == 2'd1) adj[idx] <= prod_keep;
          if (ph == 2'd2) begin
            adj[idx] <= adj[idx] - prod_keep;
            idx <= (idx == 4'd8) ? 4'd0 : idx + 4'd1;
            ph  <= '0;
          end else ph <= ph + 2'd1;
        end
        ST_DET: begin
          // ph0 issue low half, ph1 issue high half (add low), ph2 add high
          if (ph == 2'd1) det <= det + DTB'(prod);
          if (ph == 2'd2) begin
            det <= det + (DTB'(prod) <<< S);
            dj  <= dj + 2'd1;
            ph  <= '0;
          end else ph <= ph + 2'd1;
        end
        ST_CHECK: begin
          sing <= (det == '0 || det_mag < thr_sh);
          idx  <= '0;
        end
        ST_DIV_WAIT: if (div_done) begin
          inv[idx] <= sat_n(div_q);
          idx <= (idx == 4'd8) ? 4'd0 : idx + 4'd1;
          acc <= '0;
          ph  <= '0;
        end
        ST_TR: begin
          // product of idx-1 lands now; idx 9 only drains the last one
          if (ph == 2'd1) begin
            if (k_col(idx - 4'd1) == 2'd2) begin
              tr[k_row(idx - 4'd1)] <= sat_a((-tr_sum) >>> FRAC_BITS);
              acc <= '0;
            end else acc <= tr_sum;
          end
          ph <= 2'd1;
          if (idx != 4'd9) idx <= idx + 4'd1;
        end
        ST_EMIT: emit_row <= emit_row + 2'd1;
        default: ;
      endcase
    end
  end

  // result drive
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else res_valid <= (state == ST_EMIT);
    out_row  <= emit_row;
    singular <= sing;
    last_out <= (emit_row == 2'd2);
    if (sing) begin
      res_first  <= IO_BITS'(m[{emit_row, 2'd0}]);
      res_second <= IO_BITS'(m[{emit_row, 2'd1}]);
      res_third  <= IO_BITS'(m[{emit_row, 2'd2}]);
      res_offset <= IO_BITS'(m[{emit_row, 2'd3}]);
    end else begin
      res_first  <= IO_BITS'(inv[4'(emit_row * 3 + 0)]);
      res_second <= IO_BITS'(inv[4'(emit_row * 3 + 1)]);
      res_third  <= IO_BITS'(inv[4'(emit_row * 3 + 2)]);
      res_offset <= IO_BITS'(tr[emit_row]);
    end
  end

endmodule
